### src/ascii_frame_receiver_xor_checksum_top_assert.svh
// ----------------------------------------------------------------------------
// ascii frame receiver assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_RECEIVER_XOR_CHECKSUM_TOP_ASSERT_SVH
`define ASCII_FRAME_RECEIVER_XOR_CHECKSUM_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AFRX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AFRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFRX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define AFRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/afrx_pkg.sv
// ----------------------------------------------------------------------------
// afrx_pkg
// shared types and character codes for the ascii frame receiver
// ----------------------------------------------------------------------------
package afrx_pkg;

    localparam logic [7:0] CH_START      = 8'h24;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_step;
        logic emit_start;
        logic emit_load;
        logic emit_step;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic rd_zero;
        logic scan_end;
        logic match;
        logic out_taken;
        logic out_last;
    } t_dp_sts;

endpackage

### src/afrx_dp.sv
// ----------------------------------------------------------------------------
// afrx_dp
// datapath: byte decode, payload memory, checksum scan and output register
// ----------------------------------------------------------------------------
`include "ascii_frame_receiver_xor_checksum_top_assert.svh"

module afrx_dp #(
    parameter int MAX_LEN = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_ready,
    input  afrx_pkg::t_dp_cmd i_cmd,
    output afrx_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output logic [7:0]        o_payload_byte,
    output logic              o_end_of_payload
);
    import afrx_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);
    localparam logic [1:0] DIGITS_NONE = 2'd0;
    localparam logic [1:0] DIGITS_ONE  = 2'd1;
    localparam logic [1:0] DIGITS_TWO  = 2'd2;

    logic [7:0]       r_mem [MAX_LEN];
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_wr_idx;
    logic             r_in_payload;
    logic [1:0]       r_digit_cnt;
    logic [7:0]       r_rx_sum;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_xor;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_valid;

    logic             w_is_start;
    logic             w_is_star;
    logic             w_is_data;
    logic             w_close;
    logic [7:0]       w_hex;
    logic             w_we;
    logic [7:0]       w_wdata;

    assign w_is_start = (i_rx_byte == CH_START);
    assign w_is_star  = (i_rx_byte == CH_STAR);
    assign w_is_data  = !w_is_start && !w_is_star;
    assign w_hex      = (i_rx_byte > CH_NINE) ? (i_rx_byte - HEX_ALPHA_OFS)
                                              : (i_rx_byte - HEX_DIGIT_OFS);
    assign w_close    = w_is_data && !r_in_payload && (r_digit_cnt == DIGITS_ONE);
    assign w_we       = i_cmd.accept && w_is_data && (r_in_payload || w_close);
    assign w_wdata    = r_in_payload ? i_rx_byte : 8'h00;

    // payload memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_idx] <= w_wdata;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // frame parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx     <= '0;
            r_in_payload <= 1'b1;
            r_digit_cnt  <= DIGITS_NONE;
            r_rx_sum     <= '0;
        end else if (i_cmd.accept) begin
            priority if (w_is_start) begin
                r_in_payload <= 1'b1;
                r_wr_idx     <= '0;
                r_rx_sum     <= '0;
            end else if (w_is_star) begin
                r_in_payload <= 1'b0;
                r_digit_cnt  <= DIGITS_NONE;
            end else if (!r_in_payload) begin
                if (r_digit_cnt == DIGITS_NONE) begin
                    r_rx_sum    <= {w_hex[3:0], 4'h0};
                    r_digit_cnt <= DIGITS_ONE;
                end else if (r_digit_cnt == DIGITS_ONE) begin
                    r_rx_sum    <= r_rx_sum + w_hex;
                    r_digit_cnt <= DIGITS_TWO;
                end
            end else begin
                r_wr_idx <= (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + 1'b1;
            end
        end
    end

    // scan and emit pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
            r_xor <= '0;
            r_len <= '0;
        end else if (i_cmd.scan_step) begin
            r_xor <= r_xor ^ r_rd_data;
            r_len <= r_len + 1'b1;
            if (r_idx != IDX_LAST) begin
                r_idx <= r_idx + 1'b1;
            end
        end else if (i_cmd.emit_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit_step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_byte <= r_rd_data;
            r_out_last <= (LEN_W'(r_idx) + LEN_W'(1)) == r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.close     = w_close;
    assign o_sts.rd_zero   = (r_rd_data == 8'h00);
    assign o_sts.scan_end  = (r_idx == IDX_LAST);
    assign o_sts.match     = (r_xor == r_rx_sum) && (r_len != '0);
    assign o_sts.out_taken = r_out_valid && i_ready;
    assign o_sts.out_last  = r_out_last;

    assign o_valid          = r_out_valid;
    assign o_payload_byte   = r_out_byte;
    assign o_end_of_payload = r_out_last;

    `AFRX_ASSERT_SAME(a_emit_has_len, i_clk, i_rst_n, r_out_valid, r_len != '0,
                      "emit with empty payload")

endmodule

### src/afrx_ctrl.sv
// ----------------------------------------------------------------------------
// afrx_ctrl
// controller: byte intake, checksum scan sequencing and payload emit
// ----------------------------------------------------------------------------
module afrx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  afrx_pkg::t_dp_sts i_sts,
    output logic              o_ready,
    output afrx_pkg::t_dp_cmd o_cmd
);
    import afrx_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && i_sts.close) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.rd_zero) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = i_sts.scan_end ? S_CHECK : S_SCAN_RD;
                end
            end
            S_CHECK: begin
                if (i_sts.match) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_EMIT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                o_cmd.emit_load = 1'b1;
                n_state         = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_step = 1'b1;
                        n_state         = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/ascii_frame_receiver_xor_checksum_top.sv
// ----------------------------------------------------------------------------
// ascii_frame_receiver_xor_checksum_top
// receives '$'...'*hh' ascii frames and emits payloads whose xor checksum
// matches the two hex digits after '*'
// ----------------------------------------------------------------------------
// Each received byte is taken as soon as it is offered while a frame is
// being collected. The second checksum digit closes the frame: the block
// then walks the payload memory from entry 0, a read step and then a
// compare and xor step per entry, up to and including the closing zero,
// and then compares the checksum. On a match it emits the payload byte by
// byte (read, load, hand over), held by any stall from the consumer. Input
// is held off from the closing digit until the check and any emit are
// done. The payload memory has a single read port. The memory holds
// MAX_LEN bytes, so at most MAX_LEN-1 bytes are emitted per frame.
`include "ascii_frame_receiver_xor_checksum_top_assert.svh"

module ascii_frame_receiver_xor_checksum_top #(
    parameter int MAX_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_end_of_payload
);
    import afrx_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    afrx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    afrx_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_ready          (i_ready),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .o_payload_byte   (o_payload_byte),
        .o_end_of_payload (o_end_of_payload)
    );

    `AFRX_ASSERT_SAME(a_no_intake_while_emit, i_clk, i_rst_n, o_ready, !o_valid,
                      "input ready during emit")
    `AFRX_ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n,
                      o_valid && i_ready && o_end_of_payload, o_ready,
                      "no return to intake after last byte")
    `AFRX_ASSERT_NEXT(a_mid_stays_busy, i_clk, i_rst_n,
                      o_valid && i_ready && !o_end_of_payload, !o_ready && !o_valid,
                      "frame emit cut short")

endmodule

### tb/sv/afrx_payload_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afrx_payload_checker
// watches both channels of the ascii frame receiver, keeps its own copy of
// the payload store and checksum state, works out the payload transactions
// each accepted rx byte should cause and compares them in order
// ----------------------------------------------------------------------------
module afrx_payload_checker #(
    parameter int STORE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_pl_valid,
    input  logic       i_pl_ready,
    input  logic [7:0] i_pl_byte,
    input  logic       i_pl_last,
    output int         o_mismatch_count,
    output int         o_pending_count
);

    import afrx_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_beat;

    logic [7:0]    stored_bytes [STORE_DEPTH];
    int            write_ptr;
    logic          collecting;
    int            digits_seen;
    logic [7:0]    sum_received;
    t_payload_beat expected_beats [$];
    int            mismatch_count = 0;

    function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
        return (c > CH_NINE) ? c - HEX_ALPHA_OFS : c - HEX_DIGIT_OFS;
    endfunction

    task automatic absorb_rx_byte(input logic [7:0] c);
        int            len;
        logic [7:0]    sum_calc;
        t_payload_beat beat;
        if (c == CH_START) begin
            collecting   = 1'b1;
            write_ptr    = 0;
            sum_received = 8'h00;
        end else if (c == CH_STAR) begin
            collecting  = 1'b0;
            digits_seen = 0;
        end else if (!collecting) begin
            if (digits_seen == 0) begin
                sum_received = hex_digit_value(c) << 4;
                digits_seen  = 1;
            end else if (digits_seen == 1) begin
                sum_received = sum_received + hex_digit_value(c);
                digits_seen  = 2;
                // closing zero bounds the payload
                stored_bytes[write_ptr] = 8'h00;
                len      = 0;
                sum_calc = 8'h00;
                while (len < STORE_DEPTH && stored_bytes[len] != 8'h00) begin
                    sum_calc ^= stored_bytes[len];
                    len++;
                end
                if (sum_calc == sum_received && len > 0) begin
                    for (int k = 0; k < len; k++) begin
                        beat.data = stored_bytes[k];
                        beat.last = (k == len - 1);
                        expected_beats.push_back(beat);
                    end
                end
            end
        end else begin
            stored_bytes[write_ptr] = c;
            write_ptr = (write_ptr + 1) % STORE_DEPTH;
        end
    endtask

    task automatic note_mismatch(input string what, input t_payload_beat want);
        if (mismatch_count < 10)
            $display("%0t: %s: expected byte %h last %b, got byte %h last %b",
                     $time, what, want.data, want.last, i_pl_byte, i_pl_last);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (stored_bytes[i])
                stored_bytes[i] = 8'h00;
            write_ptr    = 0;
            collecting   = 1'b1;
            digits_seen  = 0;
            sum_received = 8'h00;
            expected_beats.delete();
        end else begin
            if (i_rx_valid && i_rx_ready)
                absorb_rx_byte(i_rx_byte);
            if (i_pl_valid && i_pl_ready) begin
                if (expected_beats.size() == 0) begin
                    note_mismatch("payload transaction with none pending", 'x);
                end else if (expected_beats[0].data !== i_pl_byte ||
                             expected_beats[0].last !== i_pl_last) begin
                    note_mismatch("payload transaction mismatch", expected_beats[0]);
                    void'(expected_beats.pop_front());
                end else begin
                    void'(expected_beats.pop_front());
                end
            end
        end
        o_pending_count  <= expected_beats.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives '$'...'*hh' frames into the ascii frame receiver: a short directed
// run, then random frames (valid, long and wrapping, bad checksum, empty,
// rechecked, zero-cut, interrupted, noise) with random gaps and consumer
// stalls; the checker predicts and compares the payload transactions
// ----------------------------------------------------------------------------
module testbench;

    import afrx_pkg::*;

    localparam int STORE_DEPTH  = 32;
    localparam int TOTAL_ITEMS  = 425;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 300;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte        = 8'h00;
    logic       o_valid;
    logic       i_ready          = 1'b0;
    logic [7:0] o_payload_byte;
    logic       o_end_of_payload;

    int         mismatch_count;
    int         pending_count;
    int         cycle_count      = 0;
    int         sent_count       = 0;
    int         gap_odds         = 0;
    logic       ready_stalls     = 1'b0;
    bit         drained_once     = 1'b0;
    logic [7:0] frame_q [$];
    logic [7:0] payload_q [$];

    ascii_frame_receiver_xor_checksum_top #(
        .MAX_LEN(STORE_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_payload_byte  (o_payload_byte),
        .o_end_of_payload(o_end_of_payload)
    );

    afrx_payload_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_valid),
        .i_rx_ready      (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_pl_valid      (o_valid),
        .i_pl_ready      (i_ready),
        .i_pl_byte       (o_payload_byte),
        .i_pl_last       (o_end_of_payload),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // consumer stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (ready_stalls && $urandom_range(0, 9) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        return (nibble < 10) ? HEX_DIGIT_OFS + nibble : HEX_ALPHA_OFS + nibble;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_START || b == CH_STAR);
        return b;
    endfunction

    // xor of what the store holds at close: the bytes since the last wrap,
    // cut at the first zero
    function automatic logic [7:0] stored_xor();
        int         kept;
        int         first;
        logic [7:0] x;
        kept  = payload_q.size() % STORE_DEPTH;
        first = payload_q.size() - kept;
        x     = 8'h00;
        for (int i = 0; i < kept; i++) begin
            if (payload_q[first + i] == 8'h00)
                break;
            x ^= payload_q[first + i];
        end
        return x;
    endfunction

    task automatic add_valid_frame(input int len, input bit with_zero, input bit recheck);
        logic [7:0] sum;
        payload_q.delete();
        for (int i = 0; i < len; i++)
            payload_q.push_back(body_byte());
        if (with_zero)
            payload_q[$urandom_range(0, len - 1)] = 8'h00;
        sum = stored_xor();
        frame_q.push_back(CH_START);
        foreach (payload_q[i])
            frame_q.push_back(payload_q[i]);
        frame_q.push_back(CH_STAR);
        frame_q.push_back(hex_char(sum[7:4]));
        frame_q.push_back(hex_char(sum[3:0]));
        if (recheck) begin
            frame_q.push_back(CH_STAR);
            frame_q.push_back(hex_char(sum[7:4]));
            frame_q.push_back(hex_char(sum[3:0]));
        end
    endtask

    task automatic send_rx(input logic [7:0] b);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_rx(frame_q[i]);
    endtask

    initial begin
        int kind;
        repeat (4) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        ready_stalls <= 1'b1;
        gap_odds = 4;

        // reset-state collect, recheck, empty, extremes with trailing byte, zero cut
        frame_q = '{"A", CH_STAR, "4", "1", CH_STAR, "4", "1",
                    CH_START, CH_STAR, "0", "0",
                    CH_START, 8'hFF, 8'h01, CH_STAR, "F", "E", "Z",
                    CH_START, 8'h80, 8'h00, 8'h7F, CH_STAR, "8", "0"};
        send_frame();

        while (sent_count < TOTAL_ITEMS) begin
            frame_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                add_valid_frame($urandom_range(1, 10), 1'b0, 1'b0);
                repeat ($urandom_range(0, 2))
                    frame_q.push_back(body_byte());
            end else if (kind < 68) begin
                add_valid_frame($urandom_range(28, 70), 1'b0, 1'b0);
            end else if (kind < 75) begin
                frame_q.push_back(CH_START);
                repeat ($urandom_range(1, 10))
                    frame_q.push_back(body_byte());
                frame_q.push_back(CH_STAR);
                frame_q.push_back(body_byte());
                frame_q.push_back(body_byte());
            end else if (kind < 80) begin
                add_valid_frame($urandom_range(1, 10), 1'b0, 1'b1);
            end else if (kind < 85) begin
                frame_q.push_back(CH_START);
                frame_q.push_back(CH_STAR);
                frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
                frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end else if (kind < 90) begin
                add_valid_frame($urandom_range(2, 12), 1'b1, 1'b0);
            end else if (kind < 95) begin
                frame_q.push_back(CH_START);
                repeat ($urandom_range(1, 4))
                    frame_q.push_back(body_byte());
                frame_q.push_back(CH_STAR);
                frame_q.push_back(body_byte());
                add_valid_frame($urandom_range(1, 10), 1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 6))
                    frame_q.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();

            if (!drained_once && sent_count >= 200) begin
                drained_once = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_count != 0)
                    @(posedge i_clk);
            end

            if (sent_count >= TOTAL_ITEMS - 60) begin
                gap_odds = 0;
                ready_stalls <= 1'b0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    default: gap_odds = 10;
                endcase
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/afrx_pkg.sv
src/afrx_dp.sv
src/afrx_ctrl.sv
src/ascii_frame_receiver_xor_checksum_top.sv
tb/sv/afrx_payload_checker.sv
tb/sv/testbench.sv
